### src/pixel_art_scale2x_scale3x_defines.svh
// Assertion macros for the pixel-art scaler.
`ifndef PIXEL_ART_SCALE2X_SCALE3X_DEFINES_SVH
`define PIXEL_ART_SCALE2X_SCALE3X_DEFINES_SVH

`ifndef SYNTHESIS
`define PAS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel_art_scale2x_scale3x: assertion failed");
`define PAS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel_art_scale2x_scale3x: assertion failed");
`else
`define PAS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PAS_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

### src/pas_pkg.sv
// Types, constants and the Scale2x/Scale3x block rule for the pixel-art scaler.
`timescale 1ns / 1ps
package pas_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_W      = 32;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 13;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    OP_PIXEL,
    OP_FLUSH,
    OP_FINAL
  } op_e;

  // One column of the 3x3 window.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  // Block in raster order: top left first, bottom right last.
  typedef logic [8:0][PIX_W-1:0] block_t;

  function automatic block_t scale_block(input col_t l, input col_t m, input col_t r,
                                         input logic mode3);
    block_t p;
    logic db;
    logic bf;
    logic dh;
    logic hf;
    for (int k = 0; k < 9; k++) begin
      p[k] = m.mid;
    end
    db = (l.mid == m.top);
    bf = (m.top == r.mid);
    dh = (l.mid == m.bot);
    hf = (m.bot == r.mid);
    if (m.top != m.bot && l.mid != r.mid) begin
      p[0] = db ? l.mid : m.mid;
      p[2] = bf ? r.mid : m.mid;
      p[6] = dh ? l.mid : m.mid;
      p[8] = hf ? r.mid : m.mid;
      if (mode3) begin
        p[1] = ((db && m.mid != r.top) || (bf && m.mid != l.top)) ? m.top : m.mid;
        p[3] = ((db && m.mid != l.bot) || (dh && m.mid != l.top)) ? l.mid : m.mid;
        p[5] = ((bf && m.mid != r.bot) || (hf && m.mid != r.top)) ? r.mid : m.mid;
        p[7] = ((dh && m.mid != r.bot) || (hf && m.mid != l.bot)) ? m.bot : m.mid;
      end
    end
    return p;
  endfunction

endpackage

### src/pixel_art_scale2x_scale3x.sv
// Scale2x / Scale3x pixel-art magnifier with line buffers and a 3x3 window.
`timescale 1ns / 1ps
`include "pixel_art_scale2x_scale3x_defines.svh"
// Source pixels enter in raster order, one word per clock; the block accepts a new word
// in every cycle while the result register is free or being taken. A word passes through
// two registers: the line-buffer read register at acceptance, then the result register.
// Blocks trail the input by one row and one pixel, and after the last pixel of a frame
// the user sends image_width + 1 flush words to drain the remaining blocks; the last
// of them carries frame_end. Flush words during a frame and pixel words during the
// drain are dropped. The two line memories are not cleared after reset; they are
// written before they are read in any frame, so the block is ready right after reset.
// The user writes configuration only while no word is in flight; the block itself
// does not enforce it.
module pixel_art_scale2x_scale3x
  import pas_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic [PIX_W-1:0]      pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      out_top_left_o,
  output logic [PIX_W-1:0]      out_top_o,
  output logic [PIX_W-1:0]      out_top_right_o,
  output logic [PIX_W-1:0]      out_mid_left_o,
  output logic [PIX_W-1:0]      out_centre_o,
  output logic [PIX_W-1:0]      out_mid_right_o,
  output logic [PIX_W-1:0]      out_bottom_left_o,
  output logic [PIX_W-1:0]      out_bottom_o,
  output logic [PIX_W-1:0]      out_bottom_right_o,
  output logic                  row_end_o,
  output logic                  frame_end_o
);

  localparam logic [COL_W-1:0] MaxWidthC  = COL_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0] MaxHeightC = ROW_W'(MAX_HEIGHT);

  // Configuration registers
  logic             mode_q;
  logic [COL_W-1:0] width_q;
  logic [ROW_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      width_q  <= COL_W'(320);
      height_q <= ROW_W'(240);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCALE_MODE:   mode_q   <= cfg_data_i[0];
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[COL_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  logic [COL_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;

  assign w_eff = (width_q == '0) ? COL_W'(1) : ((width_q > MaxWidthC) ? MaxWidthC : width_q);
  assign h_eff = (height_q == '0) ? ROW_W'(1) :
                 ((height_q > MaxHeightC) ? MaxHeightC : height_q);

  // Input position counters
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  // Stage 1: the accepted word with its line-buffer read data
  logic              s1_valid_q, s1_valid_d;
  op_e               s1_op_q, s1_op_d;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [PIX_W-1:0]  s1_pixel_q;
  logic              s1_load_q, s1_load_d;
  logic              s1_sel_mid_q, s1_sel_mid_d;
  logic              s1_emit_q, s1_emit_d;
  logic              s1_use_v_q, s1_use_v_d;
  logic              s1_adv;

  logic              in_acc;
  logic              pix_phase;
  logic              op_ok;
  logic              is_final;
  logic [COL_W-1:0]  c_pix;
  logic [COL_W-1:0]  w_last;
  logic [ADDR_W-1:0] rd_addr;

  assign in_acc    = in_valid_i && in_ready_o;
  assign pix_phase = (row_q < h_eff);
  assign op_ok     = pix_phase ? !kind_i : kind_i;
  assign is_final  = !pix_phase && (col_q >= w_eff);
  assign w_last    = w_eff - COL_W'(1);
  assign c_pix     = (col_q >= w_eff) ? w_last : col_q;
  assign rd_addr   = pix_phase ? c_pix[ADDR_W-1:0] : col_q[ADDR_W-1:0];

  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    s1_op_d      = OP_FLUSH;
    s1_load_d    = 1'b0;
    s1_sel_mid_d = 1'b0;
    s1_emit_d    = 1'b0;
    s1_use_v_d   = 1'b0;
    if (pix_phase) begin
      s1_op_d      = OP_PIXEL;
      s1_load_d    = (c_pix == '0);
      s1_sel_mid_d = (row_q == ROW_W'(1));
      s1_use_v_d   = (c_pix != '0) && (row_q >= ROW_W'(1));
      s1_emit_d    = s1_use_v_d || ((c_pix == '0) && (row_q >= ROW_W'(2)));
      if (c_pix == w_last) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = c_pix + COL_W'(1);
      end
    end else if (is_final) begin
      s1_op_d   = OP_FINAL;
      s1_emit_d = 1'b1;
      col_d     = '0;
      row_d     = '0;
    end else begin
      s1_load_d    = (col_q == '0);
      s1_sel_mid_d = (h_eff < ROW_W'(2));
      s1_use_v_d   = (col_q != '0);
      s1_emit_d    = s1_use_v_d || (h_eff >= ROW_W'(2));
      col_d        = col_q + COL_W'(1);
    end
  end

  logic out_valid_q;

  assign s1_adv     = s1_valid_q && (!s1_emit_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign s1_valid_d = (in_acc && op_ok) ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_acc && op_ok) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && op_ok) begin
      s1_op_q      <= s1_op_d;
      s1_addr_q    <= rd_addr;
      s1_pixel_q   <= pixel_i;
      s1_load_q    <= s1_load_d;
      s1_sel_mid_q <= s1_sel_mid_d;
      s1_emit_q    <= s1_emit_d;
      s1_use_v_q   <= s1_use_v_d;
    end
  end

  // Line memories; a read at the same edge as a write to the same entry is forwarded.
  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_rd_q, mid_rd_q;
  logic [PIX_W-1:0] fwd_up_q, fwd_mid_q;
  logic             fwd_q;
  logic             wr_en;
  logic [PIX_W-1:0] ou, om;

  assign ou    = fwd_q ? fwd_up_q : up_rd_q;
  assign om    = fwd_q ? fwd_mid_q : mid_rd_q;
  assign wr_en = s1_adv && (s1_op_q == OP_PIXEL);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      upper_mem[s1_addr_q]  <= om;
      middle_mem[s1_addr_q] <= s1_pixel_q;
    end
    if (in_acc) begin
      up_rd_q  <= upper_mem[rd_addr];
      mid_rd_q <= middle_mem[rd_addr];
      fwd_up_q  <= om;
      fwd_mid_q <= s1_pixel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc) begin
      fwd_q <= wr_en && (rd_addr == s1_addr_q);
    end
  end

  // New window column and the window itself
  col_t v;
  col_t win_q [3];

  always_comb begin
    v.top = s1_sel_mid_q ? om : ou;
    v.mid = om;
    v.bot = (s1_op_q == OP_PIXEL) ? s1_pixel_q : om;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q[0] <= '0;
      win_q[1] <= '0;
      win_q[2] <= '0;
    end else if (s1_adv && s1_op_q != OP_FINAL) begin
      win_q[0] <= s1_load_q ? v : win_q[1];
      win_q[1] <= s1_load_q ? v : win_q[2];
      win_q[2] <= v;
    end
  end

  // The block left of the new column uses it on the right; a row-end block repeats
  // its own column as the right neighbour.
  block_t blk;

  assign blk = scale_block(win_q[1], win_q[2], s1_use_v_q ? v : win_q[2], mode_q);

  // Result register
  block_t out_blk_q;
  logic   out_row_end_q;
  logic   out_frame_end_q;
  logic   out_load;

  assign out_load = s1_adv && s1_emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_blk_q       <= blk;
      out_row_end_q   <= !s1_use_v_q;
      out_frame_end_q <= (s1_op_q == OP_FINAL);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_top_left_o     = out_blk_q[0];
  assign out_top_o          = out_blk_q[1];
  assign out_top_right_o    = out_blk_q[2];
  assign out_mid_left_o     = out_blk_q[3];
  assign out_centre_o       = out_blk_q[4];
  assign out_mid_right_o    = out_blk_q[5];
  assign out_bottom_left_o  = out_blk_q[6];
  assign out_bottom_o       = out_blk_q[7];
  assign out_bottom_right_o = out_blk_q[8];
  assign row_end_o          = out_row_end_q;
  assign frame_end_o        = out_frame_end_q;

  `PAS_ASSERT_NXT(a_s1_stall_holds, clk_i, rst_ni, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_addr_q) && $stable(s1_op_q))
  `PAS_ASSERT_NXT(a_emit_loads_result, clk_i, rst_ni, out_load, out_valid_o)
  `PAS_ASSERT_NXT(a_final_restarts, clk_i, rst_ni, in_acc && op_ok && is_final, col_q == '0 && row_q == '0)
  `PAS_ASSERT_IMP(a_fwd_after_write, clk_i, rst_ni, in_acc && wr_en && rd_addr == s1_addr_q, s1_op_q == OP_PIXEL)

endmodule

### tb/sv/pixel_art_scale2x_scale3x_test.sv
// Self-checking testbench for the Scale2x/Scale3x magnifier, with a block predictor.
`timescale 1ns / 1ps
module pixel_art_scale2x_scale3x_test
  import pas_pkg::*;
();

  typedef struct packed {
    logic [8:0][PIX_W-1:0] px;
    logic                  row_end;
    logic                  frame_end;
  } scaled_block_t;

  class block_scoreboard;
    logic [PIX_W-1:0] upper_row [MAX_WIDTH];
    logic [PIX_W-1:0] mid_row [MAX_WIDTH];
    // Window columns are left, centre, right; rows are top, middle, bottom.
    logic [PIX_W-1:0] win [3][3];
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    logic             mode3;
    logic [COL_W-1:0] width_reg;
    logic [ROW_W-1:0] height_reg;
    scaled_block_t    blocks_due [$];
    int unsigned      errors;

    function new();
      for (int cl = 0; cl < 3; cl++) begin
        for (int rw = 0; rw < 3; rw++) begin
          win[cl][rw] = '0;
        end
      end
      col_cnt    = 0;
      row_cnt    = 0;
      mode3      = 1'b0;
      width_reg  = 11'd320;
      height_reg = 13'd240;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SCALE_MODE:   mode3 = val[0];
        CFG_IMAGE_WIDTH:  width_reg = val[COL_W-1:0];
        CFG_IMAGE_HEIGHT: height_reg = val[ROW_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return blocks_due.size();
    endfunction

    function scaled_block_t expand_block(int l, int m, int r, logic re, logic fe);
      scaled_block_t    blk;
      logic [PIX_W-1:0] a, b, c, d, e, f, g, h, i;
      a = win[l][0]; b = win[m][0]; c = win[r][0];
      d = win[l][1]; e = win[m][1]; f = win[r][1];
      g = win[l][2]; h = win[m][2]; i = win[r][2];
      for (int k = 0; k < 9; k++) blk.px[k] = e;
      if (b != h && d != f) begin
        blk.px[0] = (d == b) ? d : e;
        blk.px[2] = (b == f) ? f : e;
        blk.px[6] = (d == h) ? d : e;
        blk.px[8] = (h == f) ? f : e;
        if (mode3) begin
          blk.px[1] = ((d == b && e != c) || (b == f && e != a)) ? b : e;
          blk.px[3] = ((d == b && e != g) || (d == h && e != a)) ? d : e;
          blk.px[5] = ((b == f && e != i) || (h == f && e != c)) ? f : e;
          blk.px[7] = ((d == h && e != i) || (h == f && e != g)) ? h : e;
        end
      end
      blk.row_end   = re;
      blk.frame_end = fe;
      return blk;
    endfunction

    function void take_source_word(op_e op, logic [PIX_W-1:0] pix);
      int unsigned      w;
      int unsigned      h;
      int unsigned      c;
      logic [PIX_W-1:0] v [3];
      bit               lead;
      bit               trail;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      if (row_cnt < h) begin
        if (op == OP_FLUSH) return;
        c = (col_cnt >= w) ? w - 1 : col_cnt;
        v[0] = (row_cnt == 1) ? mid_row[c] : upper_row[c];
        v[1] = mid_row[c];
        v[2] = pix;
        upper_row[c] = mid_row[c];
        mid_row[c]   = pix;
        lead  = (c == 0 && row_cnt >= 2);
        trail = (c >= 1 && row_cnt >= 1);
        if (c + 1 >= w) begin
          col_cnt = 0;
          row_cnt++;
        end else begin
          col_cnt = c + 1;
        end
      end else begin
        if (op != OP_FLUSH) return;
        c = col_cnt;
        if (c >= w) begin
          // The last drain word closes the frame with the final block.
          blocks_due.push_back(expand_block(1, 2, 2, 1'b1, 1'b1));
          row_cnt = 0;
          col_cnt = 0;
          return;
        end
        v[0] = (h >= 2) ? upper_row[c] : mid_row[c];
        v[1] = mid_row[c];
        v[2] = mid_row[c];
        lead  = (c == 0 && h >= 2);
        trail = (c >= 1);
        col_cnt = c + 1;
      end
      // The block that ends the previous row uses the window before it shifts.
      if (lead) blocks_due.push_back(expand_block(1, 2, 2, 1'b1, 1'b0));
      for (int k = 0; k < 3; k++) begin
        if (c == 0) begin
          win[0][k] = v[k];
          win[1][k] = v[k];
        end else begin
          win[0][k] = win[1][k];
          win[1][k] = win[2][k];
        end
        win[2][k] = v[k];
      end
      if (trail) blocks_due.push_back(expand_block(0, 1, 2, 1'b0, 1'b0));
    endfunction

    function void note_mismatch(string what, logic [PIX_W-1:0] want, logic [PIX_W-1:0] seen);
      errors++;
      if (errors <= 10) $display("block mismatch on %s: expected %h, got %h", what, want, seen);
    endfunction

    function void check_block(scaled_block_t seen);
      scaled_block_t want;
      if (blocks_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected block with centre %h", seen.px[4]);
        return;
      end
      want = blocks_due.pop_front();
      for (int k = 0; k < 9; k++) begin
        if (seen.px[k] !== want.px[k]) note_mismatch($sformatf("pixel %0d", k), want.px[k],
                                                     seen.px[k]);
      end
      if (seen.row_end !== want.row_end) note_mismatch("row_end", want.row_end, seen.row_end);
      if (seen.frame_end !== want.frame_end) begin
        note_mismatch("frame_end", want.frame_end, seen.frame_end);
      end
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_SCALE_MODE;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  kind_i      = 1'b0;
  logic [PIX_W-1:0]      pixel_i     = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [PIX_W-1:0]      out_top_left_o;
  logic [PIX_W-1:0]      out_top_o;
  logic [PIX_W-1:0]      out_top_right_o;
  logic [PIX_W-1:0]      out_mid_left_o;
  logic [PIX_W-1:0]      out_centre_o;
  logic [PIX_W-1:0]      out_mid_right_o;
  logic [PIX_W-1:0]      out_bottom_left_o;
  logic [PIX_W-1:0]      out_bottom_o;
  logic [PIX_W-1:0]      out_bottom_right_o;
  logic                  row_end_o;
  logic                  frame_end_o;

  block_scoreboard  sb;
  logic [PIX_W-1:0] frame_pixels [$];
  int unsigned      cur_w;
  int unsigned      cur_h;
  int unsigned      hold_cycles = 0;
  bit               sender_gaps = 1'b1;
  bit               sink_stalls = 1'b1;

  pixel_art_scale2x_scale3x dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .kind_i,
    .pixel_i,
    .out_valid_o,
    .out_ready_i,
    .out_top_left_o,
    .out_top_o,
    .out_top_right_o,
    .out_mid_left_o,
    .out_centre_o,
    .out_mid_right_o,
    .out_bottom_left_o,
    .out_bottom_o,
    .out_bottom_right_o,
    .row_end_o,
    .frame_end_o
  );

  always #2 clk_i = ~clk_i;

  // Input words are noted before results are checked, so a same-edge result still finds
  // its expectation.
  always @(posedge clk_i) begin : monitor
    scaled_block_t seen;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.take_source_word(kind_i ? OP_FLUSH : OP_PIXEL, pixel_i);
      if (out_valid_o && out_ready_i) begin
        seen.px[0]     = out_top_left_o;
        seen.px[1]     = out_top_o;
        seen.px[2]     = out_top_right_o;
        seen.px[3]     = out_mid_left_o;
        seen.px[4]     = out_centre_o;
        seen.px[5]     = out_mid_right_o;
        seen.px[6]     = out_bottom_left_o;
        seen.px[7]     = out_bottom_o;
        seen.px[8]     = out_bottom_right_o;
        seen.row_end   = row_end_o;
        seen.frame_end = frame_end_o;
        sb.check_block(seen);
      end
    end
  end

  initial begin : sink
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
        out_ready_i <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 15) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_word(input op_e op, input logic [PIX_W-1:0] pix);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= (op == OP_FLUSH);
    pixel_i    <= pix;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // Waits until the block has drained, then sets up the next frame.
  task automatic program_frame(input bit mode, input int unsigned w, input int unsigned h);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    write_reg(CFG_SCALE_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    cfg_we_i <= 1'b0;
    cur_w = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    cur_h = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
  endtask

  // A small palette makes the neighbour equalities common; a few words are fully random.
  task automatic fill_frame(input int unsigned count, input int unsigned pal_n);
    logic [PIX_W-1:0] palette [4];
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 5))
        0:       palette[k] = '0;
        1:       palette[k] = '1;
        default: palette[k] = $urandom;
      endcase
    end
    frame_pixels.delete();
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 85) frame_pixels.push_back(palette[$urandom_range(0, pal_n - 1)]);
      else frame_pixels.push_back($urandom);
    end
  endtask

  // Sends the pixels, then the drain words; stray words of the wrong kind are mixed in.
  task automatic send_frame(input int unsigned noise_pct, output int unsigned counted);
    for (int k = 0; k < frame_pixels.size(); k++) begin
      if ($urandom_range(0, 99) < noise_pct) send_word(OP_FLUSH, $urandom);
      send_word(OP_PIXEL, frame_pixels[k]);
    end
    for (int k = 0; k <= cur_w; k++) begin
      if ($urandom_range(0, 99) < noise_pct) send_word(OP_PIXEL, $urandom);
      send_word(OP_FLUSH, $urandom);
    end
    if ($urandom_range(0, 99) < noise_pct) send_word(OP_FLUSH, $urandom);
    counted = frame_pixels.size() + cur_w + 1;
  endtask

  task automatic random_frame(input bit reprogram, output int unsigned counted);
    int unsigned w;
    int unsigned h;
    if (reprogram) begin
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      program_frame($urandom_range(0, 1), w, h);
    end
    fill_frame(cur_w * cur_h, $urandom_range(1, 4));
    send_frame(($urandom_range(0, 3) == 0) ? 5 : 0, counted);
  endtask

  initial begin : stimulus
    int unsigned words;
    int unsigned sent;
    sb = new();
    words = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A diagonal edge in both modes, with stray words in the first pass.
    for (int m = 0; m < 2; m++) begin
      program_frame(m[0], 3, 3);
      frame_pixels = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'h0, 32'h0,         32'hFFFF_FFFF,
                       32'h0, 32'h0,         32'h0};
      send_frame((m == 0) ? 30 : 0, sent);
    end

    // The sink holds off while the source keeps offering words, so the block backs up.
    sender_gaps = 1'b0;
    program_frame(1'b1, 8, 6);
    hold_cycles = 400;
    fill_frame(cur_w * cur_h, 3);
    send_frame(0, sent);

    while (words < 700) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      random_frame(words == 0 || $urandom_range(0, 2) == 0, sent);
      words += sent;
    end

    // Register extremes: zero sizes count as one.
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    program_frame(1'b0, 0, 0);
    fill_frame(cur_w * cur_h, 1);
    send_frame(30, sent);
    program_frame(1'b1, 0, 3);
    fill_frame(cur_w * cur_h, 2);
    send_frame(0, sent);
    program_frame(1'b0, 5, 0);
    fill_frame(cur_w * cur_h, 3);
    send_frame(0, sent);

    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    for (int k = 0; k < 6; k++) random_frame(k == 0, sent);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/pas_pkg.sv
src/pixel_art_scale2x_scale3x.sv
tb/sv/pixel_art_scale2x_scale3x_test.sv
